// ===== design/dcnt_pkg.sv =====
package dcnt_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int CNT_USE     = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
	localparam int REM_W       = (CNT_USE > 9) ? CNT_USE : 9;

	localparam logic [15:0] DEFAULT_YEAR = 16'd1900;
	localparam logic [15:0] MAX_YEAR     = 16'hFFFF;

	// year / 25 by reciprocal, low by at most one
	localparam int          RECIP_SHIFT = 21;
	localparam int          PROD_W      = 33;
	localparam int          Q25_W       = PROD_W - RECIP_SHIFT;
	localparam logic [16:0] RECIP_25    = 17'd83886;

	localparam logic OP_SET     = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
	localparam logic [PC_W-1:0] PC_MUL  = 3'd1;
	localparam logic [PC_W-1:0] PC_MOD  = 3'd2;
	localparam logic [PC_W-1:0] PC_LOAD = 3'd3;
	localparam logic [PC_W-1:0] PC_ADV  = 3'd4;
	localparam logic [PC_W-1:0] PC_EMIT = 3'd5;

	localparam logic [2:0] UOP_NONE = 3'd0;
	localparam logic [2:0] UOP_MUL  = 3'd1;
	localparam logic [2:0] UOP_MOD  = 3'd2;
	localparam logic [2:0] UOP_LOAD = 3'd3;
	localparam logic [2:0] UOP_ADV  = 3'd4;
	localparam logic [2:0] UOP_EMIT = 3'd5;

	localparam logic [2:0] COND_DISPATCH = 3'd0;
	localparam logic [2:0] COND_NEXT     = 3'd1;
	localparam logic [2:0] COND_GOTO     = 3'd2;
	localparam logic [2:0] COND_LOOP     = 3'd3;
	localparam logic [2:0] COND_EMIT     = 3'd4;

	typedef struct packed {
		logic [2:0]      uop;
		logic [2:0]      cond;
		logic [PC_W-1:0] target;
	} ucw_t;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  new_month;
		logic [4:0]  new_day;
		logic [15:0] new_year;
		logic [15:0] day_count;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  cur_month;
		logic [4:0]  cur_day;
		logic [15:0] cur_year;
		logic [4:0]  month_length;
		logic [8:0]  day_of_year;
		logic [8:0]  days_remaining;
		logic        leap;
		logic        month_defaulted;
		logic        day_defaulted;
		logic        year_defaulted;
	} rsp_t;

	function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
		case (pc)
			PC_IDLE: return '{uop: UOP_NONE, cond: COND_DISPATCH, target: PC_ADV};
			PC_MUL:  return '{uop: UOP_MUL,  cond: COND_NEXT,     target: PC_IDLE};
			PC_MOD:  return '{uop: UOP_MOD,  cond: COND_NEXT,     target: PC_IDLE};
			PC_LOAD: return '{uop: UOP_LOAD, cond: COND_GOTO,     target: PC_EMIT};
			PC_ADV:  return '{uop: UOP_ADV,  cond: COND_LOOP,     target: PC_EMIT};
			PC_EMIT: return '{uop: UOP_EMIT, cond: COND_EMIT,     target: PC_IDLE};
			default: return '{uop: UOP_NONE, cond: COND_GOTO,     target: PC_IDLE};
		endcase
	endfunction

	// ym25 is year mod 25
	function automatic logic is_leap(input logic [15:0] y, input logic [4:0] ym25);
		return (y[1:0] == 2'b00) && ((ym25 != 5'd0) || (y[3:0] == 4'b0000));
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
		case (m)
			4'd2:                               return lp ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:            return 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
			4'd10, 4'd12:                       return 5'd31;
			default:                            return 5'd30;
		endcase
	endfunction

	// days in the months before m, common year
	function automatic logic [8:0] cum_days(input logic [3:0] m);
		case (m)
			4'd2:    return 9'd31;
			4'd3:    return 9'd59;
			4'd4:    return 9'd90;
			4'd5:    return 9'd120;
			4'd6:    return 9'd151;
			4'd7:    return 9'd181;
			4'd8:    return 9'd212;
			4'd9:    return 9'd243;
			4'd10:   return 9'd273;
			4'd11:   return 9'd304;
			4'd12:   return 9'd334;
			default: return 9'd0;
		endcase
	endfunction

endpackage

// ===== design/dcnt_cmd_if.sv =====
interface dcnt_cmd_if import dcnt_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/dcnt_rsp_if.sv =====
interface dcnt_rsp_if import dcnt_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/calendar_date_counter.sv =====
// Gregorian date counter.
// cmd: one word per command, valid/ready. opcode set loads month, day and
// year after checking them; opcode advance moves the date forward by
// day_count days. rsp: one word per command, valid/ready, with the date,
// month length, day of year, days left in the year, leap flag and the
// flags showing which fields a set replaced.
// Control is a six-step microprogram with a step counter; cmd.ready is high
// only on the dispatch step, so one command is in work at a time.
// From accept to rsp.valid, a set runs the multiply and remainder steps
// for year mod 25, then load and emit. An advance repeats the advance step
// until no days are left, then emits; the advance step applies one whole
// year from January 1, one month-end rollover, or the final partial month
// per cycle.
// The next command is taken on the dispatch step that follows the emit step.
// The result sits in an output register; the next command is accepted while
// it waits. If rsp.ready stays low, the following command stalls on its
// emit step until the register frees.
// Reset gives January 1, 1900 and an empty output register.
module calendar_date_counter import dcnt_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	dcnt_cmd_if.sink    cmd,
	dcnt_rsp_if.source  rsp
);

	logic [PC_W-1:0]   pc_q;
	ucw_t              ucw;
	cmd_t              cmd_q;
	logic [4:0]        day_q;
	logic [3:0]        month_q;
	logic [15:0]       year_q;
	logic [4:0]        ym25_q;
	logic [REM_W-1:0]  rem_q;
	logic [PROD_W-1:0] prod_q;
	logic [5:0]        modr_q;
	logic              mdef_q, ddef_q, ydef_q;
	rsp_t              out_q;
	logic              out_vld_q;

	logic              accept, out_free, rem_zero;
	logic [Q25_W-1:0]  q25;
	logic [15:0]       q25_x25;
	logic [5:0]        modr_d;
	logic [4:0]        mod_fix;
	logic              raw_leap, m_ok, d_ok, y_zero;
	logic [4:0]        raw_len;
	logic              cur_leap;
	logic [4:0]        cur_len, steps;
	logic [8:0]        ylen, doy, dleft;
	logic [REM_W-1:0]  ylen_w;
	logic              year_skip, month_roll;
	logic [15:0]       ny;
	logic [4:0]        ny25;

	assign ucw       = ucode(pc_q);
	assign cmd.ready = (ucw.cond == COND_DISPATCH);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !out_vld_q || rsp.ready;
	assign rem_zero  = (rem_q == '0);
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	// set checks
	always_comb begin
		q25      = prod_q[PROD_W-1:RECIP_SHIFT];
		q25_x25  = 16'({q25, 4'b0000}) + 16'({q25, 3'b000}) + 16'(q25);
		modr_d   = 6'(cmd_q.new_year - q25_x25);
		mod_fix  = (modr_q >= 6'd25) ? 5'(modr_q - 6'd25) : modr_q[4:0];
		raw_leap = is_leap(cmd_q.new_year, mod_fix);
		m_ok     = (cmd_q.new_month >= 4'd1) && (cmd_q.new_month <= 4'd12);
		raw_len  = month_len(cmd_q.new_month, raw_leap);
		d_ok     = (cmd_q.new_day != 5'd0) && (cmd_q.new_day <= raw_len);
		y_zero   = (cmd_q.new_year == 16'd0);
	end

	// current date
	always_comb begin
		cur_leap   = is_leap(year_q, ym25_q);
		cur_len    = month_len(month_q, cur_leap);
		ylen       = cur_leap ? 9'd366 : 9'd365;
		ylen_w     = REM_W'(ylen);
		steps      = (day_q >= cur_len) ? 5'd1 : 5'(cur_len - day_q + 5'd1);
		year_skip  = (day_q == 5'd1) && (month_q == 4'd1) && (rem_q >= ylen_w);
		month_roll = (rem_q >= REM_W'(steps));
		ny         = (year_q == MAX_YEAR) ? 16'd1 : year_q + 16'd1;
		if (year_q == MAX_YEAR) begin
			ny25 = 5'd1;
		end else if (ym25_q == 5'd24) begin
			ny25 = 5'd0;
		end else begin
			ny25 = ym25_q + 5'd1;
		end
		doy   = cum_days(month_q) + 9'(cur_leap && (month_q > 4'd2)) + 9'(day_q);
		dleft = (ylen >= doy) ? ylen - doy : 9'd0;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			case (ucw.cond)
				COND_DISPATCH: begin
					if (accept) begin
						pc_q <= (cmd.data.opcode == OP_ADVANCE) ? ucw.target : pc_q + 3'd1;
					end
				end
				COND_NEXT: pc_q <= pc_q + 3'd1;
				COND_GOTO: pc_q <= ucw.target;
				COND_LOOP: begin
					if (rem_zero) begin
						pc_q <= ucw.target;
					end
				end
				COND_EMIT: begin
					if (out_free) begin
						pc_q <= ucw.target;
					end
				end
				default: pc_q <= PC_IDLE;
			endcase
		end
	end

	// date state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q   <= 5'd1;
			month_q <= 4'd1;
			year_q  <= DEFAULT_YEAR;
			ym25_q  <= 5'd0;
			rem_q   <= '0;
		end else begin
			if (accept && (cmd.data.opcode == OP_ADVANCE)) begin
				rem_q <= REM_W'(cmd.data.day_count[CNT_USE-1:0]);
			end
			case (ucw.uop)
				UOP_LOAD: begin
					month_q <= m_ok ? cmd_q.new_month : 4'd1;
					day_q   <= (m_ok && d_ok) ? cmd_q.new_day : 5'd1;
					year_q  <= y_zero ? DEFAULT_YEAR : cmd_q.new_year;
					ym25_q  <= mod_fix;
				end
				UOP_ADV: begin
					if (!rem_zero) begin
						if (year_skip) begin
							year_q <= ny;
							ym25_q <= ny25;
							rem_q  <= rem_q - ylen_w;
						end else if (month_roll) begin
							day_q <= 5'd1;
							if (month_q >= 4'd12) begin
								month_q <= 4'd1;
								year_q  <= ny;
								ym25_q  <= ny25;
							end else begin
								month_q <= month_q + 4'd1;
							end
							rem_q <= rem_q - REM_W'(steps);
						end else begin
							day_q <= day_q + rem_q[4:0];
							rem_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd.data;
			mdef_q <= 1'b0;
			ddef_q <= 1'b0;
			ydef_q <= 1'b0;
		end
		case (ucw.uop)
			UOP_MUL: prod_q <= PROD_W'({17'd0, cmd_q.new_year} * {16'd0, RECIP_25});
			UOP_MOD: modr_q <= modr_d;
			UOP_LOAD: begin
				mdef_q <= !m_ok;
				ddef_q <= !(m_ok && d_ok);
				ydef_q <= y_zero;
			end
			UOP_EMIT: begin
				if (out_free) begin
					out_q.cur_month       <= month_q;
					out_q.cur_day         <= day_q;
					out_q.cur_year        <= year_q;
					out_q.month_length    <= cur_len;
					out_q.day_of_year     <= doy;
					out_q.days_remaining  <= dleft;
					out_q.leap            <= cur_leap;
					out_q.month_defaulted <= mdef_q;
					out_q.day_defaulted   <= ddef_q;
					out_q.year_defaulted  <= ydef_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((ucw.uop == UOP_EMIT) && out_free) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(month_q >= 4'd1) && (month_q <= 4'd12))
		else $error("month out of range");

	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		(day_q >= 5'd1) && (day_q <= month_len(month_q, 1'b1)))
		else $error("day out of range");

	a_ym25_range: assert property (@(posedge clk) disable iff (!arst_n)
		ym25_q < 5'd25)
		else $error("year mod 25 out of range");

	a_idle_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == PC_IDLE) |-> rem_zero)
		else $error("day count left over at dispatch");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !rsp.ready) |=> out_vld_q && $stable(out_q))
		else $error("pending result overwritten");

endmodule
